/* rtl/core/kmel_pkg.sv */
// shared types, field widths and request codes of the key matrix edge latch
package kmel_pkg;

    // field widths of the request and result channels
    localparam int ACT_W         = 2;
    localparam int COL_FIELD_W   = 2;
    localparam int ROW_FIELD_W   = 4;
    localparam int STAMP_FIELD_W = 32;
    localparam int KEY_FIELD_W   = 12;
    localparam int SEL_W         = 4;

    // default matrix geometry and stamp storage width
    localparam int DEF_NUM_COLUMNS = 3;
    localparam int DEF_NUM_ROWS    = 4;
    localparam int DEF_STAMP_WIDTH = 32;

    // request action codes
    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EDGE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // decoded per-key command for one accepted request
    typedef struct packed {
        logic sample;     // column hit and both reads agree
        logic level;      // agreed read value
        logic edge_pass;  // edge detection pass
        logic clear;      // clear request with this key marked handled
    } t_lane_cmd;

    // per-key status bits
    typedef struct packed {
        logic level;
        logic flag;
        logic rising;
    } t_key_state;

endpackage

/* rtl/core/kmel_if.sv */
// request and result channel interfaces of the key matrix edge latch
interface kmel_in_if;
    logic                               valid;
    logic                               ready;
    logic [kmel_pkg::ACT_W-1:0]         action;
    logic [kmel_pkg::COL_FIELD_W-1:0]   column;
    logic [kmel_pkg::ROW_FIELD_W-1:0]   row_first;
    logic [kmel_pkg::ROW_FIELD_W-1:0]   row_second;
    logic [kmel_pkg::STAMP_FIELD_W-1:0] now_ms;
    logic [kmel_pkg::KEY_FIELD_W-1:0]   handled_mask;
    logic [kmel_pkg::SEL_W-1:0]         key_select;

    modport source (
        output valid, action, column, row_first, row_second, now_ms, handled_mask, key_select,
        input  ready
    );
    modport sink (
        input  valid, action, column, row_first, row_second, now_ms, handled_mask, key_select,
        output ready
    );
endinterface

interface kmel_out_if;
    logic                               valid;
    logic                               ready;
    logic [kmel_pkg::KEY_FIELD_W-1:0]   pressed_mask;
    logic [kmel_pkg::KEY_FIELD_W-1:0]   flag_mask;
    logic [kmel_pkg::KEY_FIELD_W-1:0]   rising_mask;
    logic [kmel_pkg::STAMP_FIELD_W-1:0] selected_stamp;

    modport source (
        output valid, pressed_mask, flag_mask, rising_mask, selected_stamp,
        input  ready
    );
    modport sink (
        input  valid, pressed_mask, flag_mask, rising_mask, selected_stamp,
        output ready
    );
endinterface

/* rtl/core/kmel_lane.sv */
// per-key lane: debounced level, previous level, edge flag, direction and stamp
module kmel_lane #(
    parameter int STAMP_WIDTH = kmel_pkg::DEF_STAMP_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  kmel_pkg::t_lane_cmd     i_cmd,
    input  logic [STAMP_WIDTH-1:0]  i_now,
    output kmel_pkg::t_key_state    o_next,
    output logic [STAMP_WIDTH-1:0]  o_next_stamp
);

    logic                   r_cur, r_prev, r_flag, r_dir;
    logic                   n_cur, n_prev, n_flag, n_dir;
    logic [STAMP_WIDTH-1:0] r_stamp, n_stamp;

    // next state for this key
    always_comb begin
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_flag  = r_flag;
        n_dir   = r_dir;
        n_stamp = r_stamp;
        if (i_cmd.sample) begin
            n_prev = r_cur;
            n_cur  = i_cmd.level;
        end
        if (i_cmd.edge_pass && !r_flag && (r_prev != r_cur)) begin
            n_flag  = 1'b1;
            n_dir   = r_cur;
            n_stamp = i_now;
        end
        if (i_cmd.clear) begin
            n_flag = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= 1'b0;
            r_prev  <= 1'b0;
            r_flag  <= 1'b0;
            r_dir   <= 1'b0;
            r_stamp <= '0;
        end else begin
            r_cur   <= n_cur;
            r_prev  <= n_prev;
            r_flag  <= n_flag;
            r_dir   <= n_dir;
            r_stamp <= n_stamp;
        end
    end

    // post-update view for the merge stage
    assign o_next.level  = n_cur;
    assign o_next.flag   = n_flag;
    assign o_next.rising = n_dir;
    assign o_next_stamp  = n_stamp;

`ifndef SYNTHESIS
    // flag sets only on an edge pass that saw a level change
    a_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_flag)) |->
            ($past(i_cmd.edge_pass) && ($past(r_prev) != $past(r_cur))))
        else $error("edge flag set without a qualifying edge pass");

    // flag drops only on a clear of this key
    a_flag_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_flag)) |-> $past(i_cmd.clear))
        else $error("edge flag dropped without a clear");

    // level moves only on an agreeing sample of this key
    a_level_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_cur)) |-> ($past(i_cmd.sample) && r_prev == $past(r_cur)))
        else $error("level changed without a sample");

    // stamp and direction change only together with a new flag
    a_stamp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (!$stable(r_stamp) || !$stable(r_dir))) |-> $rose(r_flag))
        else $error("edge record changed without a new flag");
`endif

endmodule

/* rtl/core/kmel_merge.sv */
// merge stage: gathers lane status into masks, selects a stamp, holds the result
module kmel_merge #(
    parameter int NUM_KEYS    = kmel_pkg::DEF_NUM_COLUMNS * kmel_pkg::DEF_NUM_ROWS,
    parameter int STAMP_WIDTH = kmel_pkg::DEF_STAMP_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [kmel_pkg::SEL_W-1:0]  i_key_select,
    input  kmel_pkg::t_key_state        i_next [NUM_KEYS],
    input  logic [STAMP_WIDTH-1:0]      i_next_stamp [NUM_KEYS],
    output logic                        o_room,
    kmel_out_if.source                  o_out
);

    localparam int KFW = kmel_pkg::KEY_FIELD_W;
    localparam int SFW = kmel_pkg::STAMP_FIELD_W;

    logic [KFW-1:0]         pressed_w, flag_w, rising_w;
    logic [STAMP_WIDTH-1:0] sel_stamp;
    logic [SFW-1:0]         stamp_w;

    logic                   r_valid;
    logic [KFW-1:0]         r_pressed, r_flag, r_rising;
    logic [SFW-1:0]         r_stamp;

    // masks over the result field, keys beyond the matrix read as zero
    for (genvar k = 0; k < KFW; k++) begin : g_mask
        if (k < NUM_KEYS) begin : g_key
            assign pressed_w[k] = i_next[k].level;
            assign flag_w[k]    = i_next[k].flag;
            assign rising_w[k]  = i_next[k].rising;
        end else begin : g_none
            assign pressed_w[k] = 1'b0;
            assign flag_w[k]    = 1'b0;
            assign rising_w[k]  = 1'b0;
        end
    end

    // and-or select of the requested key stamp, zero when out of range
    always_comb begin
        sel_stamp = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (32'(i_key_select) == k) begin
                sel_stamp = sel_stamp | i_next_stamp[k];
            end
        end
    end

    // fit stored stamp to the result field width
    if (STAMP_WIDTH >= SFW) begin : g_stamp_cut
        assign stamp_w = sel_stamp[SFW-1:0];
    end else begin : g_stamp_ext
        assign stamp_w = {{(SFW-STAMP_WIDTH){1'b0}}, sel_stamp};
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pressed <= pressed_w;
            r_flag    <= flag_w;
            r_rising  <= rising_w;
            r_stamp   <= stamp_w;
        end
    end

    assign o_room               = !r_valid || o_out.ready;
    assign o_out.valid          = r_valid;
    assign o_out.pressed_mask   = r_pressed;
    assign o_out.flag_mask      = r_flag;
    assign o_out.rising_mask    = r_rising;
    assign o_out.selected_stamp = r_stamp;

endmodule

/* rtl/core/key_matrix_edge_latch_core.sv */
// top level of the key matrix edge latch: request decode, key lanes and merge stage
//
// Key matrix scanner with a latched edge flag per key. Key k = column * NUM_ROWS + row.
// Each request (sample one column, edge pass, clear handled flags, or the unused code)
// yields exactly one result holding the pressed, flag and rising masks after that request
// and the edge stamp of the selected key. One request is taken every cycle while the
// output is not stalled; its result is held in the output register, which is the only
// stage between the channels. Every key has its own lane, so all keys update together.
// Ready drops only while a result sits in the output register and is not being taken.
module key_matrix_edge_latch_core #(
    parameter int NUM_COLUMNS = kmel_pkg::DEF_NUM_COLUMNS,
    parameter int NUM_ROWS    = kmel_pkg::DEF_NUM_ROWS,
    parameter int STAMP_WIDTH = kmel_pkg::DEF_STAMP_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kmel_in_if.sink     i_in,
    kmel_out_if.source  o_out
);

    localparam int NUM_KEYS = NUM_COLUMNS * NUM_ROWS;
    localparam int RFW      = kmel_pkg::ROW_FIELD_W;
    localparam int KFW      = kmel_pkg::KEY_FIELD_W;
    localparam int SFW      = kmel_pkg::STAMP_FIELD_W;

    logic                   room;
    logic                   accept;
    logic                   do_sample, do_edge, do_clear;
    logic [STAMP_WIDTH-1:0] now_w;

    kmel_pkg::t_lane_cmd    cmd        [NUM_KEYS];
    kmel_pkg::t_key_state   next_state [NUM_KEYS];
    logic [STAMP_WIDTH-1:0] next_stamp [NUM_KEYS];

    // request handshake and action decode
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;
    assign do_sample  = accept && (i_in.action == kmel_pkg::ACT_SAMPLE);
    assign do_edge    = accept && (i_in.action == kmel_pkg::ACT_EDGE);
    assign do_clear   = accept && (i_in.action == kmel_pkg::ACT_CLEAR);

    // fit request time to the stored stamp width
    if (STAMP_WIDTH > SFW) begin : g_now_ext
        assign now_w = {{(STAMP_WIDTH-SFW){1'b0}}, i_in.now_ms};
    end else begin : g_now_cut
        assign now_w = i_in.now_ms[STAMP_WIDTH-1:0];
    end

    // per-key command decode and lanes
    for (genvar c = 0; c < NUM_COLUMNS; c++) begin : g_col
        for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
            localparam int K = c * NUM_ROWS + r;
            logic first_b, second_b, handled_b, col_hit;

            // rows beyond the pin field read as low on both reads
            if (r < RFW) begin : g_pin
                assign first_b  = i_in.row_first[r];
                assign second_b = i_in.row_second[r];
            end else begin : g_nopin
                assign first_b  = 1'b0;
                assign second_b = 1'b0;
            end

            // keys beyond the handled field are never cleared
            if (K < KFW) begin : g_hand
                assign handled_b = i_in.handled_mask[K];
            end else begin : g_nohand
                assign handled_b = 1'b0;
            end

            assign col_hit = (32'(i_in.column) == c);

            assign cmd[K].sample    = do_sample && col_hit && (first_b == second_b);
            assign cmd[K].level     = second_b;
            assign cmd[K].edge_pass = do_edge;
            assign cmd[K].clear     = do_clear && handled_b;

            kmel_lane #(
                .STAMP_WIDTH (STAMP_WIDTH)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (cmd[K]),
                .i_now        (now_w),
                .o_next       (next_state[K]),
                .o_next_stamp (next_stamp[K])
            );
        end
    end

    // merge lanes into the result register
    kmel_merge #(
        .NUM_KEYS    (NUM_KEYS),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_key_select (i_in.key_select),
        .i_next       (next_state),
        .i_next_stamp (next_stamp),
        .o_room       (room),
        .o_out        (o_out)
    );

endmodule

/* tb/tb.sv */
// self-checking testbench of key_matrix_edge_latch_core with its own key state predictor
module tb;

    localparam int N_COLS = kmel_pkg::DEF_NUM_COLUMNS;
    localparam int N_ROWS = kmel_pkg::DEF_NUM_ROWS;
    localparam int N_KEYS = N_COLS * N_ROWS;

    localparam int AW   = kmel_pkg::ACT_W;
    localparam int CW   = kmel_pkg::COL_FIELD_W;
    localparam int RW   = kmel_pkg::ROW_FIELD_W;
    localparam int SW   = kmel_pkg::STAMP_FIELD_W;
    localparam int KW   = kmel_pkg::KEY_FIELD_W;
    localparam int SELW = kmel_pkg::SEL_W;

    // the one action code the package leaves unnamed
    localparam logic [AW-1:0] ACT_UNUSED = 2'd3;

    localparam int IDLE_PCT       = 23;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int QUIET_FIRST    = 600;
    localparam int QUIET_LAST     = 1000;
    localparam int HOLD_AT        = 1300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    typedef struct packed {
        logic [AW-1:0]   action;
        logic [CW-1:0]   column;
        logic [RW-1:0]   row_first;
        logic [RW-1:0]   row_second;
        logic [SW-1:0]   now_ms;
        logic [KW-1:0]   handled_mask;
        logic [SELW-1:0] key_select;
    } t_key_req;

    typedef struct packed {
        logic [KW-1:0] pressed_mask;
        logic [KW-1:0] flag_mask;
        logic [KW-1:0] rising_mask;
        logic [SW-1:0] selected_stamp;
    } t_key_res;

    // a request plus an optional hand-written result that overrides the predictor
    typedef struct packed {
        t_key_req req;
        logic     pinned;
        t_key_res value;
    } t_scan_row;

    typedef struct packed {
        logic     pinned;
        t_key_res value;
    } t_pin;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kmel_in_if  req_ch ();
    kmel_out_if res_ch ();

    key_matrix_edge_latch_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state of the key matrix
    logic [N_KEYS-1:0] key_cur  = '0;
    logic [N_KEYS-1:0] key_prev = '0;
    logic [N_KEYS-1:0] key_flag = '0;
    logic [N_KEYS-1:0] key_rise = '0;
    logic [SW-1:0]     key_stamp [N_KEYS] = '{default: '0};

    t_key_res    expected_q [$];
    t_pin        pinned_q [$];
    t_scan_row   scan_table [$];
    int unsigned errors       = 0;
    int unsigned n_requests   = 0;
    int unsigned n_results    = 0;
    int unsigned stall_cycles = 0;
    int unsigned act_count [4] = '{default: 0};
    bit          quiet        = 1'b0;

    // apply one request to the key state and return the masks it leaves
    function automatic t_key_res apply_request(input t_key_req r);
        t_key_res res;
        int       k;
        case (r.action)
            kmel_pkg::ACT_SAMPLE: begin
                if (r.column < N_COLS) begin
                    for (int row = 0; row < N_ROWS; row++) begin
                        if (r.row_first[row] == r.row_second[row]) begin
                            k = r.column * N_ROWS + row;
                            key_prev[k] = key_cur[k];
                            key_cur[k]  = r.row_second[row];
                        end
                    end
                end
            end
            kmel_pkg::ACT_EDGE: begin
                for (int key = 0; key < N_KEYS; key++) begin
                    if (!key_flag[key] && (key_prev[key] != key_cur[key])) begin
                        key_flag[key]  = 1'b1;
                        key_rise[key]  = key_cur[key];
                        key_stamp[key] = r.now_ms;
                    end
                end
            end
            kmel_pkg::ACT_CLEAR: key_flag = key_flag & ~r.handled_mask[N_KEYS-1:0];
            default: ;
        endcase
        res.pressed_mask   = key_cur;
        res.flag_mask      = key_flag;
        res.rising_mask    = key_rise;
        res.selected_stamp = (r.key_select < N_KEYS) ? key_stamp[r.key_select] : '0;
        return res;
    endfunction

    function automatic t_key_req build_req(
        input logic [AW-1:0]   a,
        input logic [CW-1:0]   c,
        input logic [RW-1:0]   f,
        input logic [RW-1:0]   s,
        input logic [SW-1:0]   t,
        input logic [KW-1:0]   h,
        input logic [SELW-1:0] k
    );
        return '{a, c, f, s, t, h, k};
    endfunction

    function automatic t_key_res masks(
        input logic [KW-1:0] p,
        input logic [KW-1:0] f,
        input logic [KW-1:0] r,
        input logic [SW-1:0] s
    );
        return '{p, f, r, s};
    endfunction

    task automatic add_row(input t_key_req r, input logic pinned, input t_key_res v);
        scan_table.push_back('{r, pinned, v});
    endtask

    // mostly agreeing reads on valid columns, with some bounce and noise
    function automatic t_key_req rand_request();
        t_key_req    r;
        int unsigned pick;
        r.now_ms       = $urandom();
        r.handled_mask = $urandom_range(1) ? KW'($urandom_range(4095))
                                           : KW'(1 << $urandom_range(11));
        r.key_select   = ($urandom_range(9) == 0) ? SELW'($urandom_range(15))
                                                  : SELW'($urandom_range(N_KEYS-1));
        r.column       = ($urandom_range(19) == 0) ? 2'd3 : CW'($urandom_range(N_COLS-1));
        r.row_first    = RW'($urandom_range(15));
        r.row_second   = ($urandom_range(9) < 7) ? r.row_first : RW'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 45)
            r.action = kmel_pkg::ACT_SAMPLE;
        else if (pick < 72)
            r.action = kmel_pkg::ACT_EDGE;
        else if (pick < 95)
            r.action = kmel_pkg::ACT_CLEAR;
        else
            r.action = ACT_UNUSED;
        return r;
    endfunction

    // drive one request at the falling edge and hold it until taken
    task automatic send(input t_key_req r, input logic pinned, input t_key_res v);
        while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pinned_q.push_back('{pinned, v});
        req_ch.valid        <= 1'b1;
        req_ch.action       <= r.action;
        req_ch.column       <= r.column;
        req_ch.row_first    <= r.row_first;
        req_ch.row_second   <= r.row_second;
        req_ch.now_ms       <= r.now_ms;
        req_ch.handled_mask <= r.handled_mask;
        req_ch.key_select   <= r.key_select;
        @(posedge i_clk);
        while (!(req_ch.valid && req_ch.ready))
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            errors++;
        end
    endtask

    // result side stalls
    always @(negedge i_clk) begin
        res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // predict on each accepted request, compare each accepted result, watchdog
    always @(posedge i_clk) begin
        t_key_res want;
        t_key_res got;
        t_pin     pin;
        t_key_req r;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                r = '{req_ch.action, req_ch.column, req_ch.row_first, req_ch.row_second,
                      req_ch.now_ms, req_ch.handled_mask, req_ch.key_select};
                want = apply_request(r);
                pin  = pinned_q.pop_front();
                if (pin.pinned)
                    want = pin.value;
                expected_q.push_back(want);
                act_count[r.action]++;
                n_requests++;
            end
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.pressed_mask, res_ch.flag_mask, res_ch.rising_mask,
                        res_ch.selected_stamp};
                n_results++;
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("pressed_mask", 32'(want.pressed_mask),
                                32'(got.pressed_mask));
                    check_field("flag_mask", 32'(want.flag_mask), 32'(got.flag_mask));
                    check_field("rising_mask", 32'(want.rising_mask), 32'(got.rising_mask));
                    check_field("selected_stamp", 32'(want.selected_stamp),
                                32'(got.selected_stamp));
                end
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", stall_cycles);
                $display("key_matrix_edge_latch_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        req_ch.valid        = 1'b0;
        req_ch.action       = kmel_pkg::ACT_SAMPLE;
        req_ch.column       = '0;
        req_ch.row_first    = '0;
        req_ch.row_second   = '0;
        req_ch.now_ms       = '0;
        req_ch.handled_mask = '0;
        req_ch.key_select   = '0;

        // directed scan: all keys of a column, stamp extremes, bounce, bad column,
        // unused action, out of range select, already flagged keys, clear all
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd0, 4'hF, 4'hF, 32'h0, 12'h000, 4'd0),
                1'b1, masks(12'h00F, 12'h000, 12'h000, 32'h0));
        add_row(build_req(kmel_pkg::ACT_EDGE, 2'd0, 4'h0, 4'h0, 32'hFFFF_FFFF, 12'h000, 4'd0),
                1'b1, masks(12'h00F, 12'h00F, 12'h00F, 32'hFFFF_FFFF));
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd2, 4'hF, 4'hF, 32'h0, 12'h000, 4'd0),
                1'b1, masks(12'hF0F, 12'h00F, 12'h00F, 32'hFFFF_FFFF));
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd1, 4'hA, 4'h5, 32'h0, 12'h000, 4'd3),
                1'b1, masks(12'hF0F, 12'h00F, 12'h00F, 32'hFFFF_FFFF));
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd3, 4'hF, 4'hF, 32'h0, 12'h000, 4'd8),
                1'b1, masks(12'hF0F, 12'h00F, 12'h00F, 32'h0));
        add_row(build_req(ACT_UNUSED, 2'd0, 4'hF, 4'h0, 32'h5, 12'hFFF, 4'd15),
                1'b1, masks(12'hF0F, 12'h00F, 12'h00F, 32'h0));
        add_row(build_req(kmel_pkg::ACT_EDGE, 2'd0, 4'h0, 4'h0, 32'h1234_5678, 12'h000, 4'd11),
                1'b1, masks(12'hF0F, 12'hF0F, 12'hF0F, 32'h1234_5678));
        add_row(build_req(kmel_pkg::ACT_CLEAR, 2'd0, 4'h0, 4'h0, 32'h0, 12'hFFF, 4'd11),
                1'b1, masks(12'hF0F, 12'h000, 12'hF0F, 32'h1234_5678));
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd0, 4'h0, 4'h0, 32'h0, 12'h000, 4'd12),
                1'b1, masks(12'hF00, 12'h000, 12'hF0F, 32'h0));
        add_row(build_req(kmel_pkg::ACT_EDGE, 2'd0, 4'h0, 4'h0, 32'h0, 12'h000, 4'd0),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_CLEAR, 2'd0, 4'h0, 4'h0, 32'h0, 12'h001, 4'd1),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd1, 4'h3, 4'h7, 32'h0, 12'h000, 4'd4),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_EDGE, 2'd0, 4'h0, 4'h0, 32'h8000_0001, 12'h000, 4'd4),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_CLEAR, 2'd0, 4'h0, 4'h0, 32'h0, 12'h000, 4'd5),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd1, 4'hC, 4'hC, 32'h0, 12'h000, 4'd6),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_EDGE, 2'd0, 4'h0, 4'h0, 32'h7FFF_FFFF, 12'h000, 4'd7),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_CLEAR, 2'd0, 4'h0, 4'h0, 32'h0, 12'hAAA, 4'd8),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_CLEAR, 2'd0, 4'h0, 4'h0, 32'h0, 12'h555, 4'd9),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd2, 4'h0, 4'hF, 32'h0, 12'h000, 4'd10),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd2, 4'h0, 4'h0, 32'h0, 12'h000, 4'd10),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_EDGE, 2'd0, 4'h0, 4'h0, 32'hA5A5_A5A5, 12'h000, 4'd10),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_SAMPLE, 2'd0, 4'hF, 4'hF, 32'h0, 12'h000, 4'd14),
                1'b0, '0);
        add_row(build_req(kmel_pkg::ACT_EDGE, 2'd0, 4'h0, 4'h0, 32'h1, 12'h000, 4'd0),
                1'b0, '0);

        // synchronous reset
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (scan_table[i])
            send(scan_table[i].req, scan_table[i].pinned, scan_table[i].value);

        // random scans, one gap-free stretch, one hold until all results are back
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= QUIET_FIRST) && (i < QUIET_LAST);
            if (i == HOLD_AT) begin
                req_ch.valid <= 1'b0;
                @(negedge i_clk);
                while (expected_q.size() != 0)
                    @(negedge i_clk);
            end
            send(rand_request(), 1'b0, '0);
        end
        quiet = 1'b0;
        req_ch.valid <= 1'b0;

        // drain
        while (expected_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d requests (%0d sample, %0d edge, %0d clear, %0d unused), %0d results",
                 n_requests, act_count[kmel_pkg::ACT_SAMPLE], act_count[kmel_pkg::ACT_EDGE],
                 act_count[kmel_pkg::ACT_CLEAR], act_count[ACT_UNUSED], n_results);
        $display("directed corners then random scans with stalls on both channels");
        if (errors == 0)
            $display("key_matrix_edge_latch_core verification clean");
        else
            $display("key_matrix_edge_latch_core verification failed");
        $finish;
    end

endmodule

/* key_matrix_edge_latch_core.f */
rtl/core/kmel_pkg.sv
rtl/core/kmel_if.sv
rtl/core/kmel_lane.sv
rtl/core/kmel_merge.sv
rtl/core/key_matrix_edge_latch_core.sv
tb/tb.sv
